// File: hw/rtl/bfrid_pkg.sv
// ----------------------------------------------------------------------------
// bfrid_pkg
// shared types and codes of the ready queue with remove by id
// ----------------------------------------------------------------------------
`default_nettype none

package bfrid_pkg;

  localparam int DEPTH_DEFAULT   = 16;
  localparam int ID_BITS_DEFAULT = 8;

  localparam int LIMIT_BITS = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  // operation codes
  localparam logic [1:0] F_PUSH   = 2'd0;
  localparam logic [1:0] F_POP    = 2'd1;
  localparam logic [1:0] F_REMOVE = 2'd2;
  localparam logic [1:0] F_QUERY  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] taken_id;
    logic [4:0] occupancy;
    logic       head_valid;
    logic [7:0] head_id;
  } rsp_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;       // capture the match flag
    logic occupied;  // cell holds a queued entry
    logic load;      // take the key as a new tail entry
    logic shift;     // close the gap when the chain says so
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfrid_cell.sv
// ----------------------------------------------------------------------------
// bfrid_cell
// one queue slot: holds an id, matches it, passes match and id along the row
// ----------------------------------------------------------------------------
`default_nettype none

module bfrid_cell
  import bfrid_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [ID_BITS-1:0] key,
  input  wire logic [ID_BITS-1:0] next_id,
  input  wire logic               found_in,
  input  wire logic [ID_BITS-1:0] taken_in,
  output logic                    found_out,
  output logic [ID_BITS-1:0]      taken_out,
  output logic [ID_BITS-1:0]      id_out
);

  logic [ID_BITS-1:0] id;
  logic               hit;

  // first match from the head picks this cell
  assign found_out = found_in | hit;
  assign taken_out = (hit && !found_in) ? id : taken_in;
  assign id_out    = id;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      hit <= ctrl.occupied && (id == key);
    end
    if (ctrl.load) begin
      id <= key;
    end else if (ctrl.shift && found_out) begin
      id <= next_id;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_fifo_with_remove_by_id_unit.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_remove_by_id_unit
// ordered ready queue of ids with push, pop and remove by id
// ----------------------------------------------------------------------------
// a transfer latches the match flag in every cell; in the execute state
//   first-match ripples along the cell row, the row shifts or loads and
//   the result is registered; requests stall until the sequencer is idle,
//   and a waiting result holds execution until the output register frees
// reset: count cleared, limit back to 16, output empty; cell ids not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_fifo_with_remove_by_id_unit
  import bfrid_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEFAULT,
  parameter int ID_BITS = ID_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LIMIT_BITS-1:0] cfg_wr_data,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output rsp_t                       rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state;
  logic [CW-1:0]           entry_count;
  logic [CW-1:0]           count_next;
  logic [LIMIT_BITS-1:0]   queue_limit;
  logic [1:0]              req_func;
  logic [ID_BITS-1:0]      req_key;

  logic                    req_xfer;
  logic                    exec_fire;
  logic [ID_BITS-1:0]      key;

  // cell row wiring
  cell_ctrl_t              ctrl [DEPTH];
  logic [ID_BITS-1:0]      cell_id [DEPTH];
  logic [ID_BITS-1:0]      cell_next [DEPTH];
  logic                    found [DEPTH+1];
  logic [ID_BITS-1:0]      taken [DEPTH+1];

  logic                    full;
  logic                    do_load;
  logic                    do_shift;
  logic [ID_BITS-1:0]      head_new;
  rsp_t                    rsp_next;

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign exec_fire = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // compare against the incoming id, load with the latched one
  assign key = (state == S_IDLE) ? ID_BITS'(req.thread_id) : req_key;

  // chain start: pop forces the gap at the head
  assign found[0] = (req_func == F_POP);
  assign taken[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i + 1 < DEPTH) begin : g_mid
      assign cell_next[i] = cell_id[i+1];
    end else begin : g_last
      assign cell_next[i] = '0;
    end

    always_comb begin
      ctrl[i].cmp      = req_xfer;
      ctrl[i].occupied = CW'(i) < entry_count;
      ctrl[i].load     = do_load && (entry_count == CW'(i));
      ctrl[i].shift    = do_shift;
    end

    bfrid_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .key      (key),
      .next_id  (cell_next[i]),
      .found_in (found[i]),
      .taken_in (taken[i]),
      .found_out(found[i+1]),
      .taken_out(taken[i+1]),
      .id_out   (cell_id[i])
    );
  end

  // limit is capped at the row length
  assign full = (entry_count >= CW'(DEPTH)) ||
                (CMPW'(entry_count) >= CMPW'(queue_limit));

  // decide the outcome of the latched request in the execute state
  always_comb begin
    do_load           = 1'b0;
    do_shift          = 1'b0;
    count_next        = entry_count;
    rsp_next.status   = ST_OK;
    rsp_next.taken_id = '0;
    unique case (req_func)
      F_PUSH: begin
        if (found[DEPTH]) begin
          rsp_next.status = ST_DUPLICATE;
        end else if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          do_load    = exec_fire;
          count_next = entry_count + CW'(1);
        end
      end
      F_POP: begin
        if (entry_count == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          do_shift          = exec_fire;
          count_next        = entry_count - CW'(1);
          rsp_next.taken_id = 8'(cell_id[0]);
        end
      end
      F_REMOVE: begin
        if (!found[DEPTH]) begin
          rsp_next.status = ST_NOT_FOUND;
        end else begin
          do_shift          = exec_fire;
          count_next        = entry_count - CW'(1);
          rsp_next.taken_id = 8'(taken[DEPTH]);
        end
      end
      default: begin
        // query: nothing changes
      end
    endcase

    // head as it stands after the request
    if (rsp_next.status == ST_OK && (req_func == F_POP || req_func == F_REMOVE)
        && found[1]) begin
      head_new = cell_next[0];
    end else if (rsp_next.status == ST_OK && req_func == F_PUSH
                 && entry_count == '0) begin
      head_new = req_key;
    end else begin
      head_new = cell_id[0];
    end

    rsp_next.occupancy  = 5'(count_next);
    rsp_next.head_valid = (count_next != '0);
    rsp_next.head_id    = (count_next != '0) ? 8'(head_new) : '0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_func <= req.func;
      req_key  <= ID_BITS'(req.thread_id);
    end
  end

  // count and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      queue_limit <= LIMIT_RESET;
    end else begin
      if (exec_fire) begin
        entry_count <= count_next;
      end
      if (cfg_wr_en) begin
        queue_limit <= cfg_wr_data;
      end
    end
  end

  // output register, one result waiting at most
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp <= rsp_next;
    end
  end

  // count never runs past the row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // a transfer always moves the sequencer into its execute state
  a_xfer_exec: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state == S_EXEC))
    else $error("request transfer did not start execution");

  // a successful take drops the count by one
  a_take_dec: assert property (@(posedge clk) disable iff (rst)
    exec_fire && rsp_next.status == ST_OK &&
    (req_func == F_POP || req_func == F_REMOVE)
    |=> entry_count == $past(entry_count) - CW'(1))
    else $error("count not decremented on take");

  // a refused request leaves the count alone
  a_refuse_hold: assert property (@(posedge clk) disable iff (rst)
    exec_fire && rsp_next.status != ST_OK |=> $stable(entry_count))
    else $error("count changed on refused request");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ready queue with push, pop and remove by id;
// a shadow copy of the queue predicts every result, random gaps and stalls
// exercise both handshakes, and the limit register is swept between phases
// ----------------------------------------------------------------------------

module tb_top;
  import bfrid_pkg::*;

  // clock and reset, reset held high from the start until the stimulus releases it
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // block inputs start at known values
  logic                  cfg_wr_en   = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wr_data = LIMIT_RESET;
  logic                  req_valid   = 1'b0;
  req_t                  req         = '0;
  logic                  rsp_stall   = 1'b0;

  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  bounded_fifo_with_remove_by_id_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

  // requests waiting to be driven, and results predicted but not yet seen
  req_t req_backlog [$];
  rsp_t rsp_predicted [$];

  // shadow of the queue contents, head at index 0, and of the limit register
  logic [7:0]            shadow_ids [$];
  logic [LIMIT_BITS-1:0] shadow_limit = LIMIT_RESET;

  // when set, neither side idles or stalls
  bit calm = 1'b0;

  int send_gap   = 0;
  int stall_left = 0;
  int fail_count = 0;
  int rsps_seen  = 0;
  int status_hits [0:7];

  // gap length for either side: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one request to the shadow queue and return the result it gives
  function automatic rsp_t ready_queue_apply(req_t item);
    rsp_t out;
    int   cap;
    int   pos;
    out = '0;
    out.status = ST_OK;
    // limit is capped at the number of cells
    cap = (int'(shadow_limit) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(shadow_limit);
    // first match counted from the head
    pos = -1;
    foreach (shadow_ids[i]) begin
      if (pos < 0 && shadow_ids[i] == item.thread_id) pos = i;
    end
    case (item.func)
      F_PUSH: begin
        // duplicate check wins over the full check
        if (pos >= 0) out.status = ST_DUPLICATE;
        else if (shadow_ids.size() >= cap) out.status = ST_FULL;
        else shadow_ids.push_back(item.thread_id);
      end
      F_POP: begin
        if (shadow_ids.size() == 0) out.status = ST_EMPTY;
        else out.taken_id = shadow_ids.pop_front();
      end
      F_REMOVE: begin
        // later entries close the gap, order kept
        if (pos < 0) begin
          out.status = ST_NOT_FOUND;
        end else begin
          out.taken_id = shadow_ids[pos];
          shadow_ids.delete(pos);
        end
      end
      default: begin
        // query only reports the queue
      end
    endcase
    out.occupancy  = 5'(shadow_ids.size());
    out.head_valid = (shadow_ids.size() > 0);
    out.head_id    = (shadow_ids.size() > 0) ? shadow_ids[0] : 8'h00;
    return out;
  endfunction

  // request driver: predict on each transfer, then load the next item
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_predicted.push_back(ready_queue_apply(req));
      end
      // payload only moves once the current one has transferred
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
          send_gap  = pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // result monitor: compare each transfer with the oldest prediction,
  // and drive random stalls on the result side
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        if (rsp_predicted.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, rsp);
          fail_count++;
        end else begin
          want = rsp_predicted.pop_front();
          status_hits[want.status]++;
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("taken_id", want.taken_id, rsp.taken_id);
          check_field("occupancy", 8'(want.occupancy), 8'(rsp.occupancy));
          check_field("head_valid", 8'(want.head_valid), 8'(rsp.head_valid));
          check_field("head_id", want.head_id, rsp.head_id);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp_stall  <= 1'b0;
      end
    end
  end

  task automatic send(logic [1:0] func, logic [7:0] id);
    req_t item;
    item.func      = func;
    item.thread_id = id;
    req_backlog.push_back(item);
  endtask

  // wait until every request has transferred and every result came back
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || rsp_predicted.size() != 0);
  endtask

  // limit write, only issued while the block is idle
  task automatic write_limit(logic [LIMIT_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    shadow_limit = value;
    @(negedge clk);
  endtask

  // random requests in alternating fill and drain runs; ids mostly from a
  // small pool so that duplicates and remove hits are common
  task automatic queue_random(int count);
    req_t       item;
    int         roll;
    int         run_left;
    bit         filling;
    logic [7:0] salt;
    run_left = 0;
    filling  = 1'b0;
    salt     = 8'($urandom_range(0, 7) << 5);
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        filling  = ~filling;
        run_left = $urandom_range(6, 30);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (filling) begin
        item.func = (roll < 60) ? F_PUSH : (roll < 75) ? F_POP :
                    (roll < 95) ? F_REMOVE : F_QUERY;
      end else begin
        item.func = (roll < 20) ? F_PUSH : (roll < 55) ? F_POP :
                    (roll < 95) ? F_REMOVE : F_QUERY;
      end
      if ($urandom_range(0, 99) < 70) item.thread_id = salt ^ 8'($urandom_range(0, 19));
      else item.thread_id = 8'($urandom);
      req_backlog.push_back(item);
    end
  endtask

  // stimulus sequence
  initial begin : stimulus
    logic [LIMIT_BITS-1:0] phase_limit [0:7];
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue cases, then push, duplicate, remove and pop at the reset limit
    send(F_POP, 8'h00);
    send(F_REMOVE, 8'h42);
    send(F_QUERY, 8'hff);       // query changes nothing
    send(F_PUSH, 8'h00);
    send(F_PUSH, 8'hff);
    send(F_PUSH, 8'h00);        // duplicate id
    send(F_PUSH, 8'h5a);
    send(F_PUSH, 8'ha5);
    send(F_REMOVE, 8'hff);      // middle entry, later ones close up
    send(F_REMOVE, 8'h77);      // id not queued
    send(F_QUERY, 8'h00);
    send(F_POP, 8'h33);         // pop ignores the id
    send(F_REMOVE, 8'ha5);      // tail entry
    send(F_POP, 8'h00);
    send(F_POP, 8'h00);         // now empty again
    wait_idle();

    // small limit: full push, and duplicate checked ahead of full
    write_limit(5'd2);
    send(F_PUSH, 8'h01);
    send(F_PUSH, 8'h02);
    send(F_PUSH, 8'h03);
    send(F_PUSH, 8'h01);
    wait_idle();

    // limit lowered under the count: pushes refused until it drops below
    write_limit(5'd1);
    send(F_PUSH, 8'h03);
    send(F_POP, 8'h00);
    send(F_PUSH, 8'h03);
    send(F_POP, 8'h00);
    send(F_PUSH, 8'h03);
    wait_idle();

    // zero limit refuses every push
    write_limit(5'd0);
    send(F_PUSH, 8'h04);
    send(F_REMOVE, 8'h03);
    send(F_PUSH, 8'h04);
    wait_idle();

    // random phases across limit settings, queue contents carried over
    phase_limit[0] = 5'd16;
    phase_limit[1] = 5'd3;
    phase_limit[2] = 5'd31;     // above the cell count
    phase_limit[3] = 5'd1;
    phase_limit[4] = 5'd8;
    phase_limit[5] = 5'd0;
    phase_limit[6] = 5'($urandom_range(1, 16));
    phase_limit[7] = 5'($urandom_range(0, 31));
    for (int p = 0; p < 8; p++) begin
      write_limit(phase_limit[p]);
      calm = (p == 2 || p == 6);
      queue_random((phase_limit[p] == 5'd0) ? 40 : 165);
      wait_idle();
    end

    // tail: let any stray result show up
    calm = 1'b0;
    repeat (8) @(posedge clk);
    if (rsp_predicted.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, rsp_predicted.size());
      fail_count++;
    end
    $display("checked %0d result transfers over 8 limit settings plus directed cases",
             rsps_seen);
    $display("status counts: ok %0d, full %0d, empty %0d, not found %0d, duplicate %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_NOT_FOUND], status_hits[ST_DUPLICATE]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
